// ===== rtl/rsci_pkg.sv =====
// Shared constants and types for the ray segment / circle intersection block.
// Used by the cell modules and the top level; depends on nothing else.
package rsci_pkg;

   // Fixed-point formats
   localparam int COORD_FRAC_BITS = 20;
   localparam int DIR_FRAC        = 16;
   localparam int COORD_W         = 32;
   localparam int DIR_W           = 18;
   localparam int LEN_W           = 31;
   localparam int FRAC_W          = 17;
   localparam int NORM_W          = 18;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [LEN_W-1:0] RADIUS_RESET = LEN_W'(1) << COORD_FRAC_BITS;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   // Square root chain: one root bit per cell, two radicand bits consumed per cell
   localparam int SQRT_BITS = 38;
   localparam int SQRT_DW   = 2 * SQRT_BITS;
   localparam int SQRT_RW   = SQRT_BITS + 2;

   // Divider chains: one quotient bit per cell
   localparam int QUOT_W = 17;

   // Unit normal saturation limit, Q1.16
   localparam logic [QUOT_W-1:0] NORM_ONE = QUOT_W'(65536);

endpackage

// ===== rtl/rsci_sqrt_cell.sv =====
// One cell of the integer square root chain: resolves one root bit per stage.
// Depends on rsci_pkg.
module rsci_sqrt_cell
   import rsci_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [SQRT_DW-1:0]   up_rad,
   input  logic [SQRT_RW-1:0]   up_rem,
   input  logic [SQRT_BITS-1:0] up_root,
   output logic [SQRT_DW-1:0]   dn_rad,
   output logic [SQRT_RW-1:0]   dn_rem,
   output logic [SQRT_BITS-1:0] dn_root
);

   logic [SQRT_RW+1:0]   cur;
   logic [SQRT_RW+1:0]   trial;
   logic                 fits;
   logic [SQRT_DW-1:0]   rad_in, rad_ff;
   logic [SQRT_RW-1:0]   rem_in, rem_ff;
   logic [SQRT_BITS-1:0] root_in, root_ff;

   // Bring in the next two radicand bits and try root*4+1
   always_comb begin
      cur     = {up_rem, up_rad[SQRT_DW-1 -: 2]};
      trial   = (SQRT_RW+2)'({up_root, 2'b01});
      fits    = (cur >= trial);
      rem_in  = fits ? SQRT_RW'(cur - trial) : SQRT_RW'(cur);
      root_in = {up_root[SQRT_BITS-2:0], fits};
      rad_in  = {up_rad[SQRT_DW-3:0], 2'b00};
   end

   // Hand the partial result to the next cell
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dn_rad  = rad_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;

endmodule

// ===== rtl/rsci_div_cell.sv =====
// One cell of a restoring divider chain: resolves one quotient bit per stage.
// Depends on rsci_pkg.
module rsci_div_cell
   import rsci_pkg::*;
#(
   parameter int DEN_W = LEN_W,
   parameter int QW    = QUOT_W
)
(
   input  logic             clock,
   input  logic             adv,
   input  logic [DEN_W-1:0] up_den,
   input  logic [DEN_W-1:0] up_rem,
   input  logic [QW-1:0]    up_num,
   input  logic [QW-1:0]    up_quo,
   output logic [DEN_W-1:0] dn_den,
   output logic [DEN_W-1:0] dn_rem,
   output logic [QW-1:0]    dn_num,
   output logic [QW-1:0]    dn_quo
);

   logic [DEN_W:0]   trial;
   logic             fits;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_in, rem_ff;
   logic [QW-1:0]    num_in, num_ff;
   logic [QW-1:0]    quo_in, quo_ff;

   // Shift in the next numerator bit and subtract the divisor when it fits
   always_comb begin
      trial  = {up_rem, up_num[QW-1]};
      fits   = (trial >= {1'b0, up_den});
      rem_in = fits ? DEN_W'(trial - {1'b0, up_den}) : DEN_W'(trial);
      num_in = {up_num[QW-2:0], 1'b0};
      quo_in = {up_quo[QW-2:0], fits};
   end

   // Advance to the next cell
   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= up_den;
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
      end
   end

   assign dn_den = den_ff;
   assign dn_rem = rem_ff;
   assign dn_num = num_ff;
   assign dn_quo = quo_ff;

endmodule

// ===== rtl/ray_segment_circle_intersect.sv =====
// Ray segment versus filled circle intersection. One segment word is taken per clock while
// req_ready is high. Each word passes 6 input stages, 38 square root cells, 5 back stages
// (root select, step, hit point, sign split, normal numerators), 17 divider cells and the
// output register before its result word is offered. A result that is not taken is held
// in the output register and one more in a skid register; req_ready drops only while that
// skid register is occupied. Circle center and radius are written through the csr_ port
// at byte addresses 0, 4 and 8; the user must do so only while no word is in flight, as the
// block does not enforce it. Depends on rsci_pkg, rsci_sqrt_cell and rsci_div_cell.
module ray_segment_circle_intersect
   import rsci_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // segment words
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [DIR_W-1:0]  req_dir_x,
   input  logic signed [DIR_W-1:0]  req_dir_y,
   input  logic [LEN_W-1:0]         req_seg_length,
   // result words
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic [FRAC_W-1:0]        rsp_t_fraction,
   output logic signed [NORM_W-1:0] rsp_normal_x,
   output logic signed [NORM_W-1:0] rsp_normal_y,
   // configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   typedef struct packed {
      logic               miss;
      logic signed [36:0] qd;
      logic signed [32:0] qx;
      logic signed [32:0] qy;
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic [LEN_W-1:0]   len;
   } sq_side_type;

   typedef struct packed {
      logic hit;
      logic sat_x;
      logic sat_y;
      logic neg_x;
      logic neg_y;
   } dv_side_type;

   // Round a dot product from Q(F+16) to Q F, half away from zero; magnitude only
   function automatic logic [35:0] round_dot(input logic signed [51:0] v);
      logic [51:0] m;
      m = v[51] ? 52'(-v) : 52'(v);
      return 36'((m + 52'(1 << (DIR_FRAC - 1))) >> DIR_FRAC);
   endfunction

   // Round t*dir from Q(F+16) to Q F, half away from zero
   function automatic logic signed [34:0] round_step(input logic signed [49:0] v);
      logic [49:0] m;
      logic [33:0] r;
      m = v[49] ? 50'(-v) : 50'(v);
      r = 34'((m + 50'(1 << (DIR_FRAC - 1))) >> DIR_FRAC);
      return v[49] ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

   // ---------------------------------------------------------------- configuration
   logic signed [COORD_W-1:0] center_x_ff, center_y_ff;
   logic [LEN_W-1:0]          radius_ff;
   csr_index_type             csr_index;

   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   // Write a register on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= RADIUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_pwdata;
            CSR_CENTER_Y: center_y_ff <= csr_pwdata;
            CSR_RADIUS:   radius_ff   <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_index)
         CSR_CENTER_X: csr_prdata = center_x_ff;
         CSR_CENTER_Y: csr_prdata = center_y_ff;
         CSR_RADIUS:   csr_prdata = CSR_DATA_W'(radius_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   logic adv;
   logic skid_valid_ff;
   logic out_valid_ff;

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   // ---------------------------------------------------------------- front stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [COORD_W-1:0] sx1_ff, sy1_ff;
   logic signed [DIR_W-1:0]   dx1_ff, dy1_ff, dx2_ff, dy2_ff, dx3_ff, dy3_ff;
   logic signed [DIR_W-1:0]   dx4_ff, dy4_ff, dx5_ff, dy5_ff;
   logic [LEN_W-1:0]          len1_ff, len2_ff, len3_ff, len4_ff, len5_ff;
   logic signed [32:0]        qx2_ff, qy2_ff, qx3_ff, qy3_ff, qx4_ff, qy4_ff;
   logic signed [32:0]        qx5_ff, qy5_ff;
   logic signed [50:0]        pxd3_ff, pyd3_ff;
   logic [65:0]               qxx3_ff, qyy3_ff;
   logic [61:0]               r2_3_ff, r2_4_ff;
   logic signed [51:0]        dot_in;
   logic [35:0]               mqd_in, mqd4_ff;
   logic signed [36:0]        qd4_ff, qd5_ff;
   logic [66:0]               qq4_ff;
   logic [71:0]               qd2_5_ff;
   logic signed [67:0]        base5_ff;
   logic signed [73:0]        disc_in;
   logic [SQRT_DW-1:0]        rad6_ff;
   sq_side_type               side6_ff;

   always_comb begin
      dot_in  = 52'(pxd3_ff) + 52'(pyd3_ff);
      mqd_in  = round_dot(dot_in);
      disc_in = $signed({2'b00, qd2_5_ff}) + 74'(base5_ff);
   end

   // Advance the front stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: capture the word
         sx1_ff  <= req_start_x;
         sy1_ff  <= req_start_y;
         dx1_ff  <= req_dir_x;
         dy1_ff  <= req_dir_y;
         len1_ff <= req_seg_length;
         // stage 2: offset from center
         qx2_ff  <= 33'(sx1_ff) - 33'(center_x_ff);
         qy2_ff  <= 33'(sy1_ff) - 33'(center_y_ff);
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         len2_ff <= len1_ff;
         // stage 3: products
         pxd3_ff <= qx2_ff * dx2_ff;
         pyd3_ff <= qy2_ff * dy2_ff;
         qxx3_ff <= qx2_ff * qx2_ff;
         qyy3_ff <= qy2_ff * qy2_ff;
         r2_3_ff <= radius_ff * radius_ff;
         qx3_ff  <= qx2_ff;
         qy3_ff  <= qy2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         len3_ff <= len2_ff;
         // stage 4: rounded q.dir and q.q
         mqd4_ff <= mqd_in;
         qd4_ff  <= dot_in[51] ? -$signed({1'b0, mqd_in}) : $signed({1'b0, mqd_in});
         qq4_ff  <= 67'(qxx3_ff) + 67'(qyy3_ff);
         r2_4_ff <= r2_3_ff;
         qx4_ff  <= qx3_ff;
         qy4_ff  <= qy3_ff;
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
         len4_ff <= len3_ff;
         // stage 5: qd^2 and r^2 - q.q
         qd2_5_ff <= mqd4_ff * mqd4_ff;
         base5_ff <= $signed(68'(r2_4_ff)) - $signed(68'(qq4_ff));
         qd5_ff   <= qd4_ff;
         qx5_ff   <= qx4_ff;
         qy5_ff   <= qy4_ff;
         dx5_ff   <= dx4_ff;
         dy5_ff   <= dy4_ff;
         len5_ff  <= len4_ff;
         // stage 6: discriminant and miss decision
         rad6_ff       <= disc_in[73] ? '0 : {2'b00, disc_in};
         side6_ff.miss <= (radius_ff == '0) || disc_in[73]
                          || (disc_in[72:COORD_FRAC_BITS] == '0);
         side6_ff.qd   <= qd5_ff;
         side6_ff.qx   <= qx5_ff;
         side6_ff.qy   <= qy5_ff;
         side6_ff.dx   <= dx5_ff;
         side6_ff.dy   <= dy5_ff;
         side6_ff.len  <= len5_ff;
      end
   end

   // ---------------------------------------------------------------- square root chain
   logic [SQRT_DW-1:0]   sq_rad  [SQRT_BITS+1];
   logic [SQRT_RW-1:0]   sq_rem  [SQRT_BITS+1];
   logic [SQRT_BITS-1:0] sq_root [SQRT_BITS+1];
   sq_side_type          sqs_ff  [SQRT_BITS];
   logic                 sqv_ff  [SQRT_BITS];

   assign sq_rad[0]  = rad6_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
      rsci_sqrt_cell u_cell (
         .clock   (clock),
         .adv     (adv),
         .up_rad  (sq_rad[k]),
         .up_rem  (sq_rem[k]),
         .up_root (sq_root[k]),
         .dn_rad  (sq_rad[k+1]),
         .dn_rem  (sq_rem[k+1]),
         .dn_root (sq_root[k+1])
      );
   end

   // Carry the side data alongside the root cells
   always_ff @(posedge clock) begin
      if (adv) begin
         sqs_ff[0] <= side6_ff;
         for (int k = 1; k < SQRT_BITS; k++) begin
            sqs_ff[k] <= sqs_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- back stages
   sq_side_type        sq_end;
   logic signed [39:0] nqd, root40, len40, t1, t2;
   logic               ok1, ok2;
   logic               v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   logic               hit7_ff, hit8_ff, hit9_ff, hit10_ff;
   logic [LEN_W-1:0]   t7_ff;
   logic signed [32:0] qx7_ff, qy7_ff, qx8_ff, qy8_ff;
   logic signed [17:0] dx7_ff, dy7_ff;
   logic [LEN_W-1:0]   len7_ff, len8_ff, len9_ff, len10_ff, len11_ff;
   logic signed [49:0] tdx8_ff, tdy8_ff;
   logic [47:0]        fnum8_ff, fnum9_ff, fnum10_ff, fnum11_ff;
   logic signed [34:0] px9_ff, py9_ff;
   logic [34:0]        ax10_ff, ay10_ff;
   logic               nx10_ff, ny10_ff;
   logic [51:0]        nnx_in, nny_in, sat_thr;
   logic [51:0]        nnx11_ff, nny11_ff;
   dv_side_type        side11_ff;

   always_comb begin
      sq_end = sqs_ff[SQRT_BITS-1];
      nqd    = -40'(sq_end.qd);
      root40 = $signed(40'(sq_root[SQRT_BITS]));
      len40  = $signed(40'(sq_end.len));
      t1     = nqd - root40;
      t2     = nqd + root40;
      ok1    = (t1 > 40'sd0) && (t1 < len40);
      ok2    = (t2 > 40'sd0) && (t2 < len40);
      nnx_in  = 52'({ax10_ff, 16'h0000}) + 52'(radius_ff[LEN_W-1:1]);
      nny_in  = 52'({ay10_ff, 16'h0000}) + 52'(radius_ff[LEN_W-1:1]);
      sat_thr = 52'({radius_ff, 16'h0000}) + 52'(radius_ff);
   end

   // Advance the back stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 7: pick the root inside the segment
         hit7_ff <= !sq_end.miss && (ok1 || ok2);
         t7_ff   <= ok1 ? t1[LEN_W-1:0] : t2[LEN_W-1:0];
         qx7_ff  <= sq_end.qx;
         qy7_ff  <= sq_end.qy;
         dx7_ff  <= sq_end.dx;
         dy7_ff  <= sq_end.dy;
         len7_ff <= sq_end.len;
         // stage 8: step along the direction, fraction numerator
         tdx8_ff  <= $signed({1'b0, t7_ff}) * dx7_ff;
         tdy8_ff  <= $signed({1'b0, t7_ff}) * dy7_ff;
         fnum8_ff <= 48'({t7_ff, 16'h0000}) + 48'(len7_ff[LEN_W-1:1]);
         hit8_ff  <= hit7_ff;
         qx8_ff   <= qx7_ff;
         qy8_ff   <= qy7_ff;
         len8_ff  <= len7_ff;
         // stage 9: hit point relative to center
         px9_ff   <= 35'(qx8_ff) + round_step(tdx8_ff);
         py9_ff   <= 35'(qy8_ff) + round_step(tdy8_ff);
         fnum9_ff <= fnum8_ff;
         hit9_ff  <= hit8_ff;
         len9_ff  <= len8_ff;
         // stage 10: split sign and magnitude
         ax10_ff   <= px9_ff[34] ? 35'(-px9_ff) : 35'(px9_ff);
         ay10_ff   <= py9_ff[34] ? 35'(-py9_ff) : 35'(py9_ff);
         nx10_ff   <= px9_ff[34];
         ny10_ff   <= py9_ff[34];
         fnum10_ff <= fnum9_ff;
         hit10_ff  <= hit9_ff;
         len10_ff  <= len9_ff;
         // stage 11: normal numerators and saturation check
         nnx11_ff        <= nnx_in;
         nny11_ff        <= nny_in;
         side11_ff.sat_x <= (nnx_in >= sat_thr);
         side11_ff.sat_y <= (nny_in >= sat_thr);
         side11_ff.neg_x <= nx10_ff;
         side11_ff.neg_y <= ny10_ff;
         side11_ff.hit   <= hit10_ff;
         fnum11_ff       <= fnum10_ff;
         len11_ff        <= len10_ff;
      end
   end

   // ---------------------------------------------------------------- divider chains
   logic [LEN_W-1:0]  fd_den [QUOT_W+1], fd_rem [QUOT_W+1];
   logic [QUOT_W-1:0] fd_num [QUOT_W+1], fd_quo [QUOT_W+1];
   logic [LEN_W-1:0]  xd_den [QUOT_W+1], xd_rem [QUOT_W+1];
   logic [QUOT_W-1:0] xd_num [QUOT_W+1], xd_quo [QUOT_W+1];
   logic [LEN_W-1:0]  yd_den [QUOT_W+1], yd_rem [QUOT_W+1];
   logic [QUOT_W-1:0] yd_num [QUOT_W+1], yd_quo [QUOT_W+1];
   dv_side_type       dvs_ff [QUOT_W];
   logic              dvv_ff [QUOT_W];

   assign fd_den[0] = len11_ff;
   assign fd_rem[0] = fnum11_ff[47:QUOT_W];
   assign fd_num[0] = fnum11_ff[QUOT_W-1:0];
   assign fd_quo[0] = '0;
   assign xd_den[0] = radius_ff;
   assign xd_rem[0] = nnx11_ff[QUOT_W+LEN_W-1:QUOT_W];
   assign xd_num[0] = nnx11_ff[QUOT_W-1:0];
   assign xd_quo[0] = '0;
   assign yd_den[0] = radius_ff;
   assign yd_rem[0] = nny11_ff[QUOT_W+LEN_W-1:QUOT_W];
   assign yd_num[0] = nny11_ff[QUOT_W-1:0];
   assign yd_quo[0] = '0;

   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      rsci_div_cell #(.DEN_W(LEN_W), .QW(QUOT_W)) u_frac (
         .clock (clock), .adv (adv),
         .up_den (fd_den[k]), .up_rem (fd_rem[k]), .up_num (fd_num[k]), .up_quo (fd_quo[k]),
         .dn_den (fd_den[k+1]), .dn_rem (fd_rem[k+1]), .dn_num (fd_num[k+1]),
         .dn_quo (fd_quo[k+1])
      );
      rsci_div_cell #(.DEN_W(LEN_W), .QW(QUOT_W)) u_norm_x (
         .clock (clock), .adv (adv),
         .up_den (xd_den[k]), .up_rem (xd_rem[k]), .up_num (xd_num[k]), .up_quo (xd_quo[k]),
         .dn_den (xd_den[k+1]), .dn_rem (xd_rem[k+1]), .dn_num (xd_num[k+1]),
         .dn_quo (xd_quo[k+1])
      );
      rsci_div_cell #(.DEN_W(LEN_W), .QW(QUOT_W)) u_norm_y (
         .clock (clock), .adv (adv),
         .up_den (yd_den[k]), .up_rem (yd_rem[k]), .up_num (yd_num[k]), .up_quo (yd_quo[k]),
         .dn_den (yd_den[k+1]), .dn_rem (yd_rem[k+1]), .dn_num (yd_num[k+1]),
         .dn_quo (yd_quo[k+1])
      );
   end

   // Carry flags alongside the divider cells
   always_ff @(posedge clock) begin
      if (adv) begin
         dvs_ff[0] <= side11_ff;
         for (int k = 1; k < QUOT_W; k++) begin
            dvs_ff[k] <= dvs_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         for (int k = 0; k < SQRT_BITS; k++) begin
            sqv_ff[k] <= 1'b0;
         end
         for (int k = 0; k < QUOT_W; k++) begin
            dvv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff     <= req_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         v6_ff     <= v5_ff;
         sqv_ff[0] <= v6_ff;
         for (int k = 1; k < SQRT_BITS; k++) begin
            sqv_ff[k] <= sqv_ff[k-1];
         end
         v7_ff     <= sqv_ff[SQRT_BITS-1];
         v8_ff     <= v7_ff;
         v9_ff     <= v8_ff;
         v10_ff    <= v9_ff;
         v11_ff    <= v10_ff;
         dvv_ff[0] <= v11_ff;
         for (int k = 1; k < QUOT_W; k++) begin
            dvv_ff[k] <= dvv_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- result assembly
   dv_side_type              dv_end;
   logic [QUOT_W-1:0]        mag_x, mag_y;
   logic                     res_hit;
   logic [FRAC_W-1:0]        res_frac;
   logic signed [NORM_W-1:0] res_nx, res_ny;

   always_comb begin
      dv_end   = dvs_ff[QUOT_W-1];
      mag_x    = dv_end.sat_x ? NORM_ONE : xd_quo[QUOT_W];
      mag_y    = dv_end.sat_y ? NORM_ONE : yd_quo[QUOT_W];
      res_hit  = dv_end.hit;
      res_frac = dv_end.hit ? fd_quo[QUOT_W] : '0;
      res_nx   = '0;
      res_ny   = '0;
      if (dv_end.hit) begin
         res_nx = dv_end.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
         res_ny = dv_end.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      end
   end

   // ---------------------------------------------------------------- output and skid
   logic                     take, fresh;
   logic                     out_hit_ff, skid_hit_ff;
   logic [FRAC_W-1:0]        out_frac_ff, skid_frac_ff;
   logic signed [NORM_W-1:0] out_nx_ff, out_ny_ff, skid_nx_ff, skid_ny_ff;

   assign take  = out_valid_ff && rsp_ready;
   assign fresh = adv && dvv_ff[QUOT_W-1];

   // Hold a result that is not taken; park one more in the skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (fresh) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_hit_ff  <= skid_hit_ff;
            out_frac_ff <= skid_frac_ff;
            out_nx_ff   <= skid_nx_ff;
            out_ny_ff   <= skid_ny_ff;
         end
      end else if (fresh) begin
         if (out_valid_ff && !take) begin
            skid_hit_ff  <= res_hit;
            skid_frac_ff <= res_frac;
            skid_nx_ff   <= res_nx;
            skid_ny_ff   <= res_ny;
         end else begin
            out_hit_ff  <= res_hit;
            out_frac_ff <= res_frac;
            out_nx_ff   <= res_nx;
            out_ny_ff   <= res_ny;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_t_fraction = out_frac_ff;
   assign rsp_normal_x   = out_nx_ff;
   assign rsp_normal_y   = out_ny_ff;

   // ---------------------------------------------------------------- assertions
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_stall_needs_wait: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && fresh) |=> (skid_valid_ff && !req_ready))
      else $error("arriving word not parked while output stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_t_fraction == '0 && rsp_normal_x == '0 && rsp_normal_y == '0))
      else $error("miss word carries nonzero fields");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= 18'sd65536 && rsp_normal_x >= -18'sd65536
                     && rsp_normal_y <= 18'sd65536 && rsp_normal_y >= -18'sd65536))
      else $error("normal outside unit range");

endmodule

// ===== tb/tb_ray_segment_circle_intersect.sv =====
// Testbench for ray_segment_circle_intersect, which it depends on along with rsci_pkg:
// directed and random segment words checked against a cycle-free predictor of the circle hit math.
`timescale 1ns / 1ps
module tb_ray_segment_circle_intersect;
   import rsci_pkg::*;

   localparam longint ONE = 64'd1 << COORD_FRAC_BITS;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 90;

   typedef struct packed {
      logic                     hit;
      logic [FRAC_W-1:0]        t_fraction;
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
   } hit_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_W-1:0] req_start_x = '0;
   logic signed [COORD_W-1:0] req_start_y = '0;
   logic signed [DIR_W-1:0] req_dir_x = '0;
   logic signed [DIR_W-1:0] req_dir_y = '0;
   logic [LEN_W-1:0] req_seg_length = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [FRAC_W-1:0] rsp_t_fraction;
   logic signed [NORM_W-1:0] rsp_normal_x;
   logic signed [NORM_W-1:0] rsp_normal_y;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // predictor copy of the circle registers
   longint circle_cx = 0;
   longint circle_cy = 0;
   longint circle_r = ONE;

   hit_word_type hit_q[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int hits_seen = 0;
   int idle_count = 0;

   ray_segment_circle_intersect dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint round_shift16(longint v);
      longint m;
      m = ((v < 0 ? -v : v) + 32768) >>> 16;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint m;
      m = ((num < 0 ? -num : num) + den / 2) / den;
      return num < 0 ? -m : m;
   endfunction

   function automatic longint sat_unit(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   // Work out the hit word for one segment under the current circle
   function automatic hit_word_type predict_hit(logic signed [COORD_W-1:0] sx,
         logic signed [COORD_W-1:0] sy, logic signed [DIR_W-1:0] dx,
         logic signed [DIR_W-1:0] dy, logic [LEN_W-1:0] len);
      longint qx, qy, qd, s, t1, t2, t, ln, px, py;
      logic signed [127:0] wq, wx, wy, wr, disc, c;
      logic [63:0] root;
      hit_word_type w;
      w = '0;
      qx = longint'(sx) - circle_cx;
      qy = longint'(sy) - circle_cy;
      qd = round_shift16(qx * longint'(dx) + qy * longint'(dy));
      wq = qd;
      wx = qx;
      wy = qy;
      wr = circle_r;
      disc = wq * wq + wr * wr - wx * wx - wy * wy;
      if (circle_r == 0 || disc < 128'sd1048576) return w;
      // floor square root, one bit at a time
      root = 0;
      for (int b = 37; b >= 0; b--) begin
         c = $signed({64'd0, root | (64'd1 << b)});
         if (c * c <= disc) root = root | (64'd1 << b);
      end
      s = longint'(root);
      ln = longint'(len);
      t1 = -qd - s;
      t2 = -qd + s;
      if (t1 > 0 && t1 < ln) t = t1;
      else if (t2 > 0 && t2 < ln) t = t2;
      else return w;
      px = qx + round_shift16(t * longint'(dx));
      py = qy + round_shift16(t * longint'(dy));
      w.hit = 1'b1;
      w.t_fraction = FRAC_W'(((t <<< 16) + ln / 2) / ln);
      w.normal_x = NORM_W'(sat_unit(div_round(px * 65536, circle_r)));
      w.normal_y = NORM_W'(sat_unit(div_round(py * 65536, circle_r)));
      return w;
   endfunction

   // Offer one segment word, hold it until taken, then queue its hit word
   task automatic send_segment(longint sx, longint sy, longint dx, longint dy, longint len);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_start_x <= COORD_W'(sx);
      req_start_y <= COORD_W'(sy);
      req_dir_x <= DIR_W'(dx);
      req_dir_y <= DIR_W'(dy);
      req_seg_length <= LEN_W'(len);
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      hit_q.push_back(predict_hit(req_start_x, req_start_y, req_dir_x, req_dir_y,
                                  req_seg_length));
      words_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait until every hit word is back and the pipeline is empty
   task automatic drain();
      drop_valid();
      while (hit_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_CENTER_X: circle_cx = longint'($signed(value));
         CSR_CENTER_Y: circle_cy = longint'($signed(value));
         CSR_RADIUS:   circle_r = longint'(value[LEN_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_circle(longint cx, longint cy, longint r);
      drain();
      csr_write(CSR_CENTER_X, CSR_DATA_W'(cx));
      csr_write(CSR_CENTER_Y, CSR_DATA_W'(cy));
      csr_write(CSR_RADIUS, CSR_DATA_W'(r));
   endtask

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Segment that starts near the circle and points roughly at it
   task automatic send_aimed_segment();
      longint span, ox, oy, len;
      real ang;
      span = clamp(circle_r * 3, 4, 64'h7FFF_FFFF);
      ox = longint'($urandom_range(32'(2 * span))) - span;
      oy = longint'($urandom_range(32'(2 * span))) - span;
      ang = $atan2(-real'(oy), -real'(ox)) + (real'($urandom_range(2000)) - 1000.0) / 1400.0;
      len = clamp(longint'($urandom_range(32'(clamp(span * 3, 2, 64'h7FFF_FFFE)))), 1,
                  64'h7FFF_FFFF);
      send_segment(clamp(circle_cx + ox, -(64'd1 << 31), (64'd1 << 31) - 1),
                   clamp(circle_cy + oy, -(64'd1 << 31), (64'd1 << 31) - 1),
                   longint'($rtoi(65536.0 * $cos(ang))), longint'($rtoi(65536.0 * $sin(ang))),
                   len);
   endtask

   task automatic send_noise_segment();
      send_segment(longint'($signed($urandom)), longint'($signed($urandom)),
                   longint'($urandom_range(131072)) - 65536,
                   longint'($urandom_range(131072)) - 65536,
                   longint'($urandom_range(32'h7FFF_FFFF, 1)));
   endtask

   task automatic send_random_mix(int count);
      repeat (count) begin
         if ($urandom_range(99) < 80) send_aimed_segment();
         else send_noise_segment();
      end
   endtask

   // Hand-picked segments against the unit circle at the origin
   task automatic test_directed();
      send_segment(-2 * ONE, 0, 65536, 0, 4 * ONE);          // clean hit from outside
      send_segment(0, 0, 0, 65536, 2 * ONE);                 // start inside, far root
      send_segment(-2 * ONE, 2 * ONE, 65536, 0, 4 * ONE);    // clear miss
      send_segment(-2 * ONE, ONE - 1, 65536, 0, 4 * ONE);    // grazing, tiny discriminant
      send_segment(-2 * ONE, ONE - 2000, 65536, 0, 4 * ONE); // grazing, just above
      send_segment(-2 * ONE, 0, 65536, 0, ONE);              // root equals length
      send_segment(-2 * ONE, 0, 65536, 0, ONE + 1);          // fraction rounds to one
      send_segment(-2 * ONE, 0, 65536, 0, 1);                // minimum length
      send_segment(2 * ONE, 2 * ONE, -65536, -65536, 64'h7FFF_FFFF); // non-unit direction
      send_segment(0, 0, 0, 0, 4 * ONE);                     // zero direction
      send_segment(64'h7FFF_FFFF, -(64'd1 << 31), -65536, 65536, 64'h7FFF_FFFF);
      send_segment(-(64'd1 << 31), 64'h7FFF_FFFF, 65536, -65536, 64'h7FFF_FFFF);
      send_segment(ONE / 2, ONE / 2, -46341, -46341, 3 * ONE);
      send_segment(3 * ONE, 0, -65536, 0, 64'h7FFF_FFFF);
      send_segment(0, -3 * ONE, 0, 65536, 2 * ONE);          // stops short
   endtask

   task automatic test_extreme_circles();
      set_circle(0, 0, 1);                                   // one-LSB radius
      send_segment(-4, 0, 65536, 0, 16);
      send_segment(-ONE, 0, 65536, 0, 2 * ONE);
      set_circle(0, 0, 64'h7FFF_FFFF);                       // largest radius
      send_segment(0, 0, 65536, 0, 64'h7FFF_FFFF);
      send_segment(-(64'd1 << 31), 0, 65536, 0, 64'h7FFF_FFFF);
      send_random_mix(20);
      set_circle(64'h7FFF_FFFF, -(64'd1 << 31), 64'h7FFF_FFFF);
      send_random_mix(20);
      set_circle(-(64'd1 << 31), 64'h7FFF_FFFF, ONE);
      send_random_mix(20);
   endtask

   task automatic test_random(int count, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      set_circle(longint'($signed($urandom)) >>> 2, longint'($signed($urandom)) >>> 2,
                 longint'($urandom_range(64 * ONE, ONE / 16)));
      send_random_mix(count);
   endtask

   // Stall the result side long enough to fill the block and stop its input
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain();
      hold_cycles = 300;
      send_random_mix(150);
   endtask

   // Result side: random stalls, or one long hold when asked
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each result word with the oldest queued hit word
   always @(posedge clock) begin
      hit_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_q.size() == 0) begin
            $display("%0t: unexpected result word hit=%0b", $time, rsp_hit);
            errors++;
         end else begin
            exp_w = hit_q.pop_front();
            words_checked++;
            if (rsp_hit) hits_seen++;
            if (rsp_hit !== exp_w.hit || rsp_t_fraction !== exp_w.t_fraction ||
                rsp_normal_x !== exp_w.normal_x || rsp_normal_y !== exp_w.normal_y) begin
               $display("%0t: expected hit=%0b frac=%0d nx=%0d ny=%0d, got hit=%0b frac=%0d nx=%0d ny=%0d",
                        $time, exp_w.hit, exp_w.t_fraction, exp_w.normal_x, exp_w.normal_y,
                        rsp_hit, rsp_t_fraction, rsp_normal_x, rsp_normal_y);
               errors++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d words outstanding", $time, hit_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_extreme_circles();
      test_random(400, 33, 67);
      test_random(400, 67, 33);
      test_random(300, 0, 0);
      test_backpressure();
      drain();
      $display("Covered %0d segment words, %0d checked, %0d hits, over several circles",
               words_sent, words_checked, hits_seen);
      if (errors == 0 && hit_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
